[rtl/b64d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and the character classifier for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // ascii codes that bound the alphabet ranges
  localparam logic [7:0] CharUpperA = 8'd65;
  localparam logic [7:0] CharUpperZ = 8'd90;
  localparam logic [7:0] CharLowerA = 8'd97;
  localparam logic [7:0] CharLowerZ = 8'd122;
  localparam logic [7:0] CharDigit0 = 8'd48;
  localparam logic [7:0] CharDigit9 = 8'd57;
  localparam logic [7:0] CharPlus   = 8'd43;
  localparam logic [7:0] CharSlash  = 8'd47;

  // sextet values of the range starts and the two symbols
  localparam logic [5:0] SxtLowerBase = 6'd26;
  localparam logic [5:0] SxtDigitBase = 6'd52;
  localparam logic [5:0] SxtPlus      = 6'd62;
  localparam logic [5:0] SxtSlash     = 6'd63;

  // bytes carried by one group, most significant byte first
  localparam int unsigned GrpBytes = 3;

  // classified character: hit flag and six-bit value
  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } sextet_t;

  // one group of decoded bytes handed from front to back
  typedef struct packed {
    logic [8*GrpBytes-1:0] bytes;
    logic [1:0]            nbytes;
    logic                  last;
  } group_t;

  // map an ascii character to its sextet, hit low for skipped characters
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t    s;
    logic [7:0] diff;
    s    = '0;
    diff = '0;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      diff    = c - CharUpperA;
      s.hit   = 1'b1;
      s.value = diff[5:0];
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      diff    = c - CharLowerA;
      s.hit   = 1'b1;
      s.value = diff[5:0] + SxtLowerBase;
    end else if (c >= CharDigit0 && c <= CharDigit9) begin
      diff    = c - CharDigit0;
      s.hit   = 1'b1;
      s.value = diff[5:0] + SxtDigitBase;
    end else if (c == CharPlus) begin
      s.hit   = 1'b1;
      s.value = SxtPlus;
    end else if (c == CharSlash) begin
      s.hit   = 1'b1;
      s.value = SxtSlash;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[rtl/b64d_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d channel interfaces
// Valid/ready channels for text characters in and decoded bytes out.
// ----------------------------------------------------------------------------
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input last,
                  output ready);
endinterface
`default_nettype wire

[rtl/b64d_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them and packs sextets into byte groups.
// ----------------------------------------------------------------------------
module b64d_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    char_valid_i,
  output logic                   char_ready_o,
  input  wire  [7:0]             char_in_i,
  input  wire                    end_of_text_i,
  output logic                   grp_valid_o,
  input  wire                    grp_ready_i,
  output b64d_pkg::group_t       grp_o
);

  logic [17:0]         buf_q, buf_d, buf_upd;
  logic [1:0]          cnt_q, cnt_d, cnt_upd;
  b64d_pkg::sextet_t   sx;
  logic                fire;
  logic                complete;

  assign char_ready_o = grp_ready_i;
  assign fire         = char_valid_i && grp_ready_i;
  assign sx           = b64d_pkg::sextet_of(char_in_i);
  assign complete     = sx.hit && (cnt_q == 2'd3);

  // shift a new sextet into the pending buffer
  always_comb begin
    buf_upd = buf_q;
    cnt_upd = cnt_q;
    if (sx.hit && !complete) begin
      buf_upd = {buf_q[11:0], sx.value};
      cnt_upd = cnt_q + 2'd1;
    end
  end

  // group formed by this character
  always_comb begin
    grp_o = '0;
    if (complete) begin
      grp_o.bytes  = {buf_q, sx.value};
      grp_o.nbytes = 2'd3;
      grp_o.last   = end_of_text_i;
    end else begin
      grp_o.last = 1'b1;
      case (cnt_upd)
        2'd2: begin
          grp_o.bytes  = {buf_upd[11:4], 16'h0000};
          grp_o.nbytes = 2'd1;
        end
        2'd3: begin
          grp_o.bytes  = {buf_upd[17:2], 8'h00};
          grp_o.nbytes = 2'd2;
        end
        default: begin
          grp_o.bytes  = '0;
          grp_o.nbytes = 2'd0;
        end
      endcase
    end
  end

  assign grp_valid_o = char_valid_i && (complete || end_of_text_i);

  // pending state, cleared after each full group and at end of text
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (fire) begin
      if (complete || end_of_text_i) begin
        buf_d = '0;
        cnt_d = '0;
      end else begin
        buf_d = buf_upd;
        cnt_d = cnt_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
    end else begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[rtl/b64d_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_queue
// Two-entry group queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_valid_i,
  output logic                   push_ready_o,
  input  wire b64d_pkg::group_t  push_grp_i,
  output logic                   pop_valid_o,
  input  wire                    pop_ready_i,
  output b64d_pkg::group_t       pop_grp_o,
  output logic [1:0]             count_o
);

  b64d_pkg::group_t  slot_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_grp_o    = slot_q[rd_ptr_q];
  assign count_o      = cnt_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_grp_i;
    end
  end

endmodule
`default_nettype wire

[rtl/b64d_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_back
// Takes groups from the queue; one beat per byte, one empty beat if none.
// ----------------------------------------------------------------------------
module b64d_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    grp_valid_i,
  output logic                   grp_ready_o,
  input  wire b64d_pkg::group_t  grp_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic [7:0]             data_byte_o,
  output logic                   byte_valid_o,
  output logic                   last_o
);

  b64d_pkg::group_t  grp_q, grp_d;
  logic              busy_q, busy_d;
  logic [1:0]        idx_q, idx_d;
  logic [1:0]        final_idx;
  logic              fire, done_beat, load;

  assign final_idx = (grp_q.nbytes == 2'd0) ? 2'd0 : grp_q.nbytes - 2'd1;
  assign fire      = busy_q && out_ready_i;
  assign done_beat = fire && (idx_q == final_idx);
  assign load      = grp_valid_i && (!busy_q || done_beat);
  assign grp_ready_o = !busy_q || done_beat;

  // working group and byte index
  always_comb begin
    grp_d  = grp_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      grp_d  = grp_i;
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (done_beat) begin
      busy_d = 1'b0;
    end else if (fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  // byte select, most significant first
  always_comb begin
    case (idx_q)
      2'd0:    data_byte_o = grp_q.bytes[23:16];
      2'd1:    data_byte_o = grp_q.bytes[15:8];
      default: data_byte_o = grp_q.bytes[7:0];
    endcase
  end

  assign out_valid_o  = busy_q;
  assign byte_valid_o = (grp_q.nbytes != 2'd0);
  assign last_o       = grp_q.last && (idx_q == final_idx);

endmodule
`default_nettype wire

[rtl/base64_stream_decoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming base64 decoder: characters in, decoded bytes out.
//
//   channel   dir  beat payload
//   text_i    in   char_in[7:0], end_of_text
//   bytes_o   out  data_byte[7:0], byte_valid, last
//
// Takes one character per cycle if the queue has room; every fourth alphabet
// character yields a group of three output beats, so the byte side never needs
// more than one beat per character and keeps pace with an unstalled receiver.
// A two-entry group queue sits between the classifier and the byte sender,
// so the text side keeps flowing while bytes wait downstream, until both
// slots are full.
// Reset is asynchronous and clears all control and pending sextets.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  b64d_char_if.sink    text_i,
  b64d_byte_if.source  bytes_o
);

  logic              f_valid, f_ready;
  b64d_pkg::group_t  f_grp;
  logic              b_valid, b_ready;
  b64d_pkg::group_t  b_grp;
  logic [1:0]        q_count;

  // classify and pack
  b64d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_valid_i  (text_i.valid),
    .char_ready_o  (text_i.ready),
    .char_in_i     (text_i.char_in),
    .end_of_text_i (text_i.end_of_text),
    .grp_valid_o   (f_valid),
    .grp_ready_i   (f_ready),
    .grp_o         (f_grp)
  );

  // group queue
  b64d_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_grp_i   (f_grp),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_grp_o    (b_grp),
    .count_o      (q_count)
  );

  // byte sender
  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grp_valid_i  (b_valid),
    .grp_ready_o  (b_ready),
    .grp_i        (b_grp),
    .out_valid_o  (bytes_o.valid),
    .out_ready_i  (bytes_o.ready),
    .data_byte_o  (bytes_o.data_byte),
    .byte_valid_o (bytes_o.byte_valid),
    .last_o       (bytes_o.last)
  );

`ifndef SYNTHESIS
  // a beat without a byte only closes a text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_o.valid && !bytes_o.byte_valid |-> bytes_o.last)
    else $error("empty beat without last");

  // queue fill never exceeds its two slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count != 2'd3)
    else $error("group queue overflow");

  // an accepted end of text always lands a group in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_i.valid && text_i.ready && text_i.end_of_text |-> f_valid && f_ready)
    else $error("end of text lost");
`endif

endmodule
`default_nettype wire

[test/base64_stream_decoder_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_top_test
// Feeds directed and random base64 text into the decoder over the character
// channel and checks every byte beat against an in-bench decoder, through
// phases of sender gaps, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------

// one beat on the byte channel
typedef struct packed {
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;
} byte_beat_t;

// decodes accepted characters and holds the byte beats still owed
class b64_byte_checker;
  byte_beat_t  due_beats[$];
  logic [17:0] held_sextets;
  logic [1:0]  held_count;
  int          errors;
  int          beats_checked;
  int          marker_beats;
  int          texts_closed;

  function new();
    held_sextets  = '0;
    held_count    = '0;
    errors        = 0;
    beats_checked = 0;
    marker_beats  = 0;
    texts_closed  = 0;
  endfunction

  // {hit, value}; hit low for characters outside the alphabet
  function logic [6:0] classify(input logic [7:0] c);
    logic [6:0] cls;
    cls = '0;
    if (c >= b64d_pkg::CharUpperA && c <= b64d_pkg::CharUpperZ)
      cls = {1'b1, c[5:0] - b64d_pkg::CharUpperA[5:0]};
    else if (c >= b64d_pkg::CharLowerA && c <= b64d_pkg::CharLowerZ)
      cls = {1'b1, c[5:0] - b64d_pkg::CharLowerA[5:0] + 6'd26};
    else if (c >= b64d_pkg::CharDigit0 && c <= b64d_pkg::CharDigit9)
      cls = {1'b1, c[5:0] - b64d_pkg::CharDigit0[5:0] + 6'd52};
    else if (c == b64d_pkg::CharPlus)
      cls = {1'b1, 6'd62};
    else if (c == b64d_pkg::CharSlash)
      cls = {1'b1, 6'd63};
    return cls;
  endfunction

  function void owe(input logic [7:0] b, input logic bv, input logic lst);
    byte_beat_t beat;
    beat.data_byte  = b;
    beat.byte_valid = bv;
    beat.last       = lst;
    due_beats.push_back(beat);
  endfunction

  // accepted character: advance the decoder and queue the beats it causes
  function void take_char(input logic [7:0] c, input logic eot);
    logic [6:0]  cls;
    logic [23:0] grp;
    byte_beat_t  tail;
    bit          full_group;
    cls        = classify(c);
    full_group = 1'b0;
    if (cls[6]) begin
      if (held_count == 2'd3) begin
        grp = {held_sextets, cls[5:0]};
        owe(grp[23:16], 1'b1, 1'b0);
        owe(grp[15:8], 1'b1, 1'b0);
        owe(grp[7:0], 1'b1, 1'b0);
        held_sextets = '0;
        held_count   = '0;
        full_group   = 1'b1;
      end else begin
        held_sextets = {held_sextets[11:0], cls[5:0]};
        held_count   = held_count + 2'd1;
      end
    end
    if (eot) begin
      if (full_group) begin
        tail      = due_beats.pop_back();
        tail.last = 1'b1;
        due_beats.push_back(tail);
      end else if (held_count == 2'd2) begin
        grp = {held_sextets[11:0], 12'h000};
        owe(grp[23:16], 1'b1, 1'b1);
      end else if (held_count == 2'd3) begin
        grp = {held_sextets, 6'h00};
        owe(grp[23:16], 1'b1, 1'b0);
        owe(grp[15:8], 1'b1, 1'b1);
      end else begin
        // nothing pending or a lone sextet: end marker without data
        owe(8'h00, 1'b0, 1'b1);
      end
      held_sextets = '0;
      held_count   = '0;
      texts_closed++;
    end
  endfunction

  // accepted byte beat: compare with the oldest owed beat
  function void check_beat(input logic [7:0] b, input logic bv, input logic lst);
    byte_beat_t want;
    beats_checked++;
    if (bv == 1'b0)
      marker_beats++;
    if (due_beats.size() == 0) begin
      errors++;
      $display("%0t: unexpected beat data=%02h byte_valid=%0b last=%0b",
               $time, b, bv, lst);
    end else begin
      want = due_beats.pop_front();
      if (want.data_byte !== b || want.byte_valid !== bv || want.last !== lst) begin
        errors++;
        $display("%0t: beat mismatch: expected data=%02h byte_valid=%0b last=%0b,",
                 $time, want.data_byte, want.byte_valid, want.last);
        $display("%0t:   got data=%02h byte_valid=%0b last=%0b",
                 $time, b, bv, lst);
      end
    end
  endfunction

  function int pending();
    return due_beats.size();
  endfunction
endclass

module base64_stream_decoder_top_test;

  localparam int          PhaseChars    = 30;
  localparam int          RxHoldCycles  = 80;
  localparam int          WatchdogLimit = 2000;
  localparam int          TailCycles    = 16;
  localparam logic [7:0]  PadChar       = 8'h3d;

  logic clk_i;
  logic rst_ni;

  b64d_char_if text_if ();
  b64d_byte_if bytes_if ();

  base64_stream_decoder_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_if),
    .bytes_o (bytes_if)
  );

  b64_byte_checker checker_sb;
  int              tx_gap_pct;
  int              rx_stall_pct;
  bit              rx_hold_req;
  int              chars_sent;
  int              idle_cycles;

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // beat monitors: note accepted characters before checking bytes
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (text_if.valid && text_if.ready)
        checker_sb.take_char(text_if.char_in, text_if.end_of_text);
      if (bytes_if.valid && bytes_if.ready)
        checker_sb.check_beat(bytes_if.data_byte, bytes_if.byte_valid, bytes_if.last);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (text_if.valid && text_if.ready) ||
        (bytes_if.valid && bytes_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d beats still owed", $time, checker_sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // byte receiver: random stalls, plus a long hold-off on request
  initial begin
    bytes_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        bytes_if.ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
      end
      bytes_if.ready <= (32'($urandom_range(99)) >= rx_stall_pct);
    end
  end

  // alphabet character for a sextet
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return b64d_pkg::CharUpperA + {2'b00, v};
    if (v < 6'd52) return b64d_pkg::CharLowerA + {2'b00, v - 6'd26};
    if (v < 6'd62) return b64d_pkg::CharDigit0 + {2'b00, v - 6'd52};
    if (v == 6'd62) return b64d_pkg::CharPlus;
    return b64d_pkg::CharSlash;
  endfunction

  // random character outside the alphabet
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    logic [6:0] cls;
    do begin
      c   = 8'($urandom);
      cls = checker_sb.classify(c);
    end while (cls[6]);
    return c;
  endfunction

  // offer one character and hold it until accepted
  task automatic send_char(input logic [7:0] c, input logic eot);
    while (32'($urandom_range(99)) < tx_gap_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_if.valid       <= 1'b1;
    text_if.char_in     <= c;
    text_if.end_of_text <= eot;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_string(input string s, input bit close);
    int i;
    for (i = 0; i < s.len(); i++)
      send_char(s[i], close && (i == s.len() - 1));
  endtask

  // encode random bytes as one text, optionally padded and with stray chars
  task automatic send_text(input int nbytes, input bit noisy, input bit padded);
    logic [7:0]  chars[$];
    logic [23:0] grp;
    int          i;
    int          k;
    int          nsx;
    chars = {};
    for (i = 0; i < nbytes; i += 3) begin
      grp = 24'($urandom);
      nsx = (nbytes - i >= 3) ? 4 : nbytes - i + 1;
      for (k = 0; k < nsx; k++)
        chars.push_back(sextet_char(grp[23 - 6 * k -: 6]));
      if (padded)
        for (k = nsx; k < 4; k++)
          chars.push_back(PadChar);
    end
    if (chars.size() == 0)
      chars.push_back(PadChar);
    for (i = 0; i < chars.size(); i++) begin
      if (noisy && $urandom_range(5) == 0)
        send_char(noise_char(), 1'b0);
      send_char(chars[i], i == chars.size() - 1);
    end
  endtask

  // sender pause until every owed beat is back
  task automatic drain();
    text_if.valid <= 1'b0;
    @(posedge clk_i);
    while (checker_sb.pending() != 0) @(posedge clk_i);
  endtask

  // main sequence
  initial begin
    int phase;
    int phase_start;
    checker_sb   = new();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    rx_hold_req  = 1'b0;
    chars_sent   = 0;
    idle_cycles  = 0;
    rst_ni       = 1'b0;
    text_if.valid       <= 1'b0;
    text_if.char_in     <= 8'h00;
    text_if.end_of_text <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_gap_pct = 70; rx_stall_pct = 0;  end
        2:       begin tx_gap_pct = 0;  rx_stall_pct = 70; end
        default: begin tx_gap_pct = 32; rx_stall_pct = 32; end
      endcase
      if (phase == 0) begin
        // group completed by the closing char
        send_string("TWFu", 1'b1);
        // two sextets then padding closes: one byte
        send_string("QQ==", 1'b1);
        // three sextets at close: two bytes
        send_string("AB/", 1'b1);
        // lone sextet at close is dropped
        send_string("z", 1'b1);
        // skipped char closing an empty text
        send_char(8'hff, 1'b1);
        // every alphabet range edge, then a skipped closer after full groups
        send_string("+/09azAZ", 1'b0);
        send_char(8'h80, 1'b1);
        // long receiver hold-off while the sender keeps going
        rx_hold_req = 1'b1;
        send_text(12, 1'b0, 1'b1);
      end
      phase_start = chars_sent;
      while (chars_sent - phase_start < PhaseChars) begin
        if ($urandom_range(99) < 80)
          send_text(($urandom_range(3) == 0) ? 32'($urandom_range(9, 4))
                                             : 32'($urandom_range(4)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          send_char(8'($urandom), $urandom_range(7) == 0);
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d characters in %0d texts over four idle/stall phases",
             chars_sent, checker_sb.texts_closed);
    $display("Checked %0d byte beats, %0d of them end markers without data",
             checker_sb.beats_checked, checker_sb.marker_beats);
    if (checker_sb.errors == 0 && checker_sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
rtl/b64d_pkg.sv
rtl/b64d_if.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder_top.sv
test/base64_stream_decoder_top_test.sv
